FILE: rtl/core/cmw_pkg.sv
package cmw_pkg;

   // geometry
   localparam int COLUMNS     = 320;
   localparam int SCREEN_ROWS = 200;

   // item and register field widths
   localparam int OP_W       = 2;
   localparam int COL_W      = 10;
   localparam int RND_W      = 8;
   localparam int ROW_W      = 9;
   localparam int START_W    = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   // derived widths
   localparam int H_MAX     = SCREEN_ROWS * 2;
   localparam int START_MAX = (1 << START_W) - 1;
   localparam int OFS_MAX   = (H_MAX > START_MAX) ? H_MAX : START_MAX;
   localparam int OFS_W     = $clog2(OFS_MAX + 1) + 1;
   localparam int H_W       = $clog2(H_MAX + 1);
   localparam int ADDR_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int PTR_W     = $clog2(COLUMNS + 1);

   typedef enum logic [OP_W-1:0] {
      OP_SEED  = 2'd0,
      OP_TICK  = 2'd1,
      OP_QUERY = 2'd2
   } cmw_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_HEIGHT = 1'd0,
      CSR_HIGH_RES     = 1'd1
   } cmw_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_QUERY,
      ST_TICK,
      ST_EMIT
   } cmw_state_type;

   typedef logic signed [OFS_W-1:0] cmw_ofs_type;

   typedef struct packed {
      logic accept;
      logic seed_wr;
      logic query_rd;
      logic sweep_run;
      logic tick_end;
      logic emit;
   } cmw_cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic out_free;
   } cmw_status_type;

   // byte mod 3: 4 is 1 mod 3, so sum the 2-bit digits and reduce the small sum
   function automatic logic [1:0] mod3_byte(input logic [RND_W-1:0] r);
      logic [3:0] s;
      logic [1:0] m;
      s = {2'b00, r[1:0]} + {2'b00, r[3:2]} + {2'b00, r[5:4]} + {2'b00, r[7:6]};
      unique case (s)
         4'd0, 4'd3, 4'd6, 4'd9, 4'd12: m = 2'd0;
         4'd1, 4'd4, 4'd7, 4'd10:       m = 2'd1;
         4'd2, 4'd5, 4'd8, 4'd11:       m = 2'd2;
         default:                       m = 2'd0;
      endcase
      return m;
   endfunction

endpackage

FILE: rtl/core/cmw_req_if.sv
interface cmw_req_if;
   logic                       valid;
   logic                       ready;
   logic [cmw_pkg::OP_W-1:0]   operation;
   logic [cmw_pkg::COL_W-1:0]  column;
   logic [cmw_pkg::RND_W-1:0]  random_byte;
   logic [cmw_pkg::ROW_W-1:0]  row;

   modport source (output valid, operation, column, random_byte, row, input ready);
   modport sink   (input valid, operation, column, random_byte, row, output ready);
endinterface

FILE: rtl/core/cmw_rsp_if.sv
interface cmw_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       take_old;
   logic [cmw_pkg::ROW_W-1:0]  old_row;
   logic                       finished;
   logic                       in_progress;

   modport source (output valid, take_old, old_row, finished, in_progress, input ready);
   modport sink   (input valid, take_old, old_row, finished, in_progress, output ready);
endinterface

FILE: rtl/core/column_melt_wipe_core.sv
// sequence: after accept a seed passes the seed-write state, a query the query-read state,
//   a tick the column sweep (one column read per cycle), an unused code none; then emit
// throughput: one item at a time; ready comes back in the cycle the result shows up, so
//   a new item is taken only once the previous result is in the output register
// reset: synchronous, active high; clears config, wipe flag, previous offset and handshakes;
//   the offset memory is not cleared and holds garbage until seeded
module column_melt_wipe_core (
   input  logic                           clock,
   input  logic                           reset,
   cmw_req_if.sink                        req_bus,
   cmw_rsp_if.source                      rsp_bus,
   input  logic                           csr_we,
   input  logic [cmw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cmw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cmw_pkg::*;

   // command and status between the sequencer and the datapath
   cmw_cmd_type    cmd;
   cmw_status_type status;

   // sequencer: takes an item from idle, runs seed, query or the column sweep,
   // then waits for the output register to free up
   cmw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.operation),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: offset memory (one write, one registered read port), seed arithmetic,
   // pipelined read-modify-write sweep for ticks, query compare and the output register
   cmw_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_operation   (req_bus.operation),
      .req_column      (req_bus.column),
      .req_random_byte (req_bus.random_byte),
      .req_row         (req_bus.row),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_take_old    (rsp_bus.take_old),
      .rsp_old_row     (rsp_bus.old_row),
      .rsp_finished    (rsp_bus.finished),
      .rsp_in_progress (rsp_bus.in_progress)
   );

endmodule

FILE: rtl/core/cmw_ctrl.sv
module cmw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [cmw_pkg::OP_W-1:0] req_op,
   output logic                     req_ready,
   input  cmw_pkg::cmw_status_type  status,
   output cmw_pkg::cmw_cmd_type     cmd
);
   import cmw_pkg::*;

   cmw_state_type state_ff;
   cmw_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (req_op)
                  OP_SEED:  state_in = ST_SEED;
                  OP_TICK:  state_in = ST_TICK;
                  OP_QUERY: state_in = ST_QUERY;
                  default:  state_in = ST_EMIT;
               endcase
            end
         end
         ST_SEED: begin
            cmd.seed_wr = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_QUERY: begin
            cmd.query_rd = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_TICK: begin
            cmd.sweep_run = 1'b1;
            if (status.sweep_done) begin
               cmd.tick_end = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/core/cmw_dp.sv
module cmw_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  cmw_pkg::cmw_cmd_type           cmd,
   output cmw_pkg::cmw_status_type        status,
   input  logic                           csr_we,
   input  logic [cmw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cmw_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [cmw_pkg::OP_W-1:0]       req_operation,
   input  logic [cmw_pkg::COL_W-1:0]      req_column,
   input  logic [cmw_pkg::RND_W-1:0]      req_random_byte,
   input  logic [cmw_pkg::ROW_W-1:0]      req_row,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_take_old,
   output logic [cmw_pkg::ROW_W-1:0]      rsp_old_row,
   output logic                           rsp_finished,
   output logic                           rsp_in_progress
);
   import cmw_pkg::*;

   localparam int SW = OFS_W + 1;
   localparam logic signed [SW-1:0] ONE     = SW'(1);
   localparam logic signed [SW-1:0] EIGHT   = SW'(8);
   localparam logic signed [SW-1:0] SIXTEEN = SW'(16);
   localparam logic signed [SW-1:0] NEG16   = SW'(-16);
   localparam logic signed [SW-1:0] NEG15   = SW'(-15);

   // configuration
   logic [START_W-1:0] start_ff;
   logic               high_res_ff;

   // latched item
   logic [OP_W-1:0]  op_ff;
   logic [COL_W-1:0] col_ff;
   logic [RND_W-1:0] rnd_ff;
   logic [ROW_W-1:0] row_ff;

   // offset store
   logic [OFS_W-1:0] ofs_mem [0:COLUMNS-1];
   cmw_ofs_type      rd_data_ff;
   logic             rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;
   cmw_ofs_type      wr_data;

   // seed and wipe state
   cmw_ofs_type prev_ff;
   logic        active_ff;
   logic        active_in;
   logic        fin_ff;

   // sweep
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic              wr_vld_ff;
   logic              wr_vld_in;
   logic [ADDR_W-1:0] wr_addr_ff;
   logic              moved_ff;
   logic              moved_in;
   logic              rd_issue;

   // output register
   logic             out_vld_ff;
   logic             out_vld_in;
   logic             out_take_ff;
   logic [ROW_W-1:0] out_orow_ff;
   logic             out_fin_ff;
   logic             out_prog_ff;

   // combinational results
   logic [H_W-1:0]      h_u;
   logic signed [SW-1:0] h_s;
   logic                seed_in_rng;
   cmw_ofs_type         seed_val;
   logic signed [SW-1:0] seed_sum;
   logic signed [SW-1:0] w;
   logic signed [SW-1:0] dy;
   logic signed [SW-1:0] w_dy;
   logic signed [SW-1:0] new_w;
   logic                mv;
   logic [COL_W-1:0]    lc;
   logic                q_in_rng;
   logic [OFS_W-2:0]    q_d;
   logic [OFS_W-2:0]    q_row;
   logic [OFS_W-2:0]    q_h;
   logic                q_take;
   logic [ROW_W-1:0]    q_orow;

   assign h_u = high_res_ff ? H_W'(SCREEN_ROWS * 2) : H_W'(SCREEN_ROWS);
   assign h_s = $signed({{(SW-H_W){1'b0}}, h_u});

   // seed value
   assign seed_in_rng = {{(32-COL_W){1'b0}}, col_ff} < 32'(COLUMNS);

   always_comb begin
      seed_sum = {prev_ff[OFS_W-1], prev_ff} + $signed({{(SW-2){1'b0}}, mod3_byte(rnd_ff)})
                 - ONE;
      if (col_ff == '0) begin
         seed_val = OFS_W'($signed({{(SW-START_W){1'b0}}, start_ff})
                           - $signed({{(SW-4){1'b0}}, rnd_ff[3:0]}));
      end else if (seed_sum > $signed(SW'(0))) begin
         seed_val = '0;
      end else if (seed_sum == NEG16) begin
         seed_val = OFS_W'(NEG15);
      end else begin
         seed_val = OFS_W'(seed_sum);
      end
   end

   // per-column tick step on the word read last cycle
   always_comb begin
      w    = {rd_data_ff[OFS_W-1], rd_data_ff};
      dy   = (w < SIXTEEN) ? (w + ONE) : EIGHT;
      w_dy = w + dy;
      if (w < $signed(SW'(0))) begin
         new_w = w + ONE;
         mv    = 1'b1;
      end else if (w < h_s) begin
         new_w = (w_dy >= h_s) ? h_s : w_dy;
         mv    = 1'b1;
      end else begin
         new_w = w;
         mv    = 1'b0;
      end
   end

   // pixel query on the word read for the query
   always_comb begin
      lc       = high_res_ff ? {1'b0, col_ff[COL_W-1:1]} : col_ff;
      q_in_rng = {{(32-COL_W){1'b0}}, lc} < 32'(COLUMNS);
      q_d      = rd_data_ff[OFS_W-1] ? '0 : rd_data_ff[OFS_W-2:0];
      q_row    = {{(OFS_W-1-ROW_W){1'b0}}, row_ff};
      q_h      = {{(OFS_W-1-H_W){1'b0}}, h_u};
      q_take   = q_in_rng && (q_row >= q_d) && (q_row < q_h);
      q_orow   = q_take ? ROW_W'(q_row - q_d) : '0;
   end

   // memory port selection
   assign rd_issue = cmd.sweep_run && (rd_ptr_ff < PTR_W'(COLUMNS));
   assign rd_en    = cmd.query_rd || rd_issue;
   assign rd_addr  = cmd.query_rd ? lc[ADDR_W-1:0] : rd_ptr_ff[ADDR_W-1:0];
   assign wr_en    = (cmd.seed_wr && seed_in_rng) || (cmd.sweep_run && wr_vld_ff);
   assign wr_addr  = cmd.seed_wr ? col_ff[ADDR_W-1:0] : wr_addr_ff;
   assign wr_data  = cmd.seed_wr ? seed_val : OFS_W'(new_w);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ofs_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ofs_mem[rd_addr];
      end
   end

   // control next values
   always_comb begin
      rd_ptr_in  = rd_ptr_ff;
      wr_vld_in  = wr_vld_ff;
      moved_in   = moved_ff;
      active_in  = active_ff;
      out_vld_in = out_vld_ff;
      if (cmd.accept) begin
         rd_ptr_in = '0;
         wr_vld_in = 1'b0;
         moved_in  = 1'b0;
      end else if (cmd.sweep_run) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(rd_issue);
         wr_vld_in = rd_issue;
         if (wr_vld_ff && mv) begin
            moved_in = 1'b1;
         end
      end
      if (cmd.seed_wr && seed_in_rng) begin
         active_in = 1'b1;
      end else if (cmd.tick_end && !moved_ff) begin
         active_in = 1'b0;
      end
      if (cmd.emit) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= '0;
         high_res_ff <= 1'b0;
         prev_ff     <= '0;
         active_ff   <= 1'b0;
         rd_ptr_ff   <= '0;
         wr_vld_ff   <= 1'b0;
         moved_ff    <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_START_HEIGHT) begin
            start_ff <= csr_wdata[START_W-1:0];
         end
         if (csr_we && csr_index == CSR_HIGH_RES) begin
            high_res_ff <= csr_wdata[0];
         end
         if (cmd.seed_wr && seed_in_rng) begin
            prev_ff <= seed_val;
         end
         active_ff  <= active_in;
         rd_ptr_ff  <= rd_ptr_in;
         wr_vld_ff  <= wr_vld_in;
         moved_ff   <= moved_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_operation;
         col_ff <= req_column;
         rnd_ff <= req_random_byte;
         row_ff <= req_row;
      end
      if (cmd.sweep_run) begin
         wr_addr_ff <= rd_ptr_ff[ADDR_W-1:0];
      end
      if (cmd.tick_end) begin
         fin_ff <= !moved_ff;
      end
      if (cmd.emit) begin
         out_take_ff <= (op_ff == OP_QUERY) && q_take;
         out_orow_ff <= (op_ff == OP_QUERY) ? q_orow : '0;
         out_fin_ff  <= (op_ff == OP_TICK) && fin_ff;
         out_prog_ff <= active_ff;
      end
   end

   assign status.sweep_done = (rd_ptr_ff == PTR_W'(COLUMNS)) && !wr_vld_ff;
   assign status.out_free   = !out_vld_ff || rsp_ready;

   assign rsp_valid       = out_vld_ff;
   assign rsp_take_old    = out_take_ff;
   assign rsp_old_row     = out_orow_ff;
   assign rsp_finished    = out_fin_ff;
   assign rsp_in_progress = out_prog_ff;

endmodule

FILE: rtl/core/column_melt_wipe_checker.sv
module column_melt_wipe_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_take_old,
   input logic [cmw_pkg::ROW_W-1:0] rsp_old_row,
   input logic                      rsp_finished,
   input logic                      rsp_in_progress
);
   import cmw_pkg::*;

   // items accepted whose result has not been taken
   logic [1:0] pending_ff;
   logic [1:0] pending_in;

   always_comb begin
      pending_in = pending_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without an accepted item");

   a_bounded_pending: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two items outstanding");

   a_row_zero_when_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_take_old |-> rsp_old_row == '0)
      else $error("old_row set without take_old");

   a_finished_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> !rsp_in_progress && !rsp_take_old)
      else $error("finished tick still reports wipe active");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_old_row))
      else $error("stalled result dropped or changed");

endmodule

bind column_melt_wipe_core column_melt_wipe_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_take_old    (rsp_bus.take_old),
   .rsp_old_row     (rsp_bus.old_row),
   .rsp_finished    (rsp_bus.finished),
   .rsp_in_progress (rsp_bus.in_progress)
);

FILE: tb/sv/tb_column_melt_wipe_core.sv
`timescale 1ns / 1ps

module tb_column_melt_wipe_core;
   import cmw_pkg::*;

   // timing and run length
   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 11;
   localparam int ITEM_TARGET   = 950;
   localparam int MAX_GAP       = 14;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam int TAIL_CYCLES   = 16;
   localparam int TICK_CAP      = 90;
   localparam int LIMIT_CYCLES  = 2_500_000;

   // operation code the block does not use
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // one request item and one result item
   typedef struct {
      logic [OP_W-1:0]  op;
      logic [COL_W-1:0] col;
      logic [RND_W-1:0] rnd;
      logic [ROW_W-1:0] row;
   } melt_item_type;

   typedef struct {
      logic             take_old;
      logic [ROW_W-1:0] old_row;
      logic             finished;
      logic             in_progress;
   } melt_answer_type;

   // directed table row: optional register update, optional full seed pass, the item,
   // and a typed-in answer where it is obvious
   typedef struct {
      bit               set_cfg;
      logic [START_W-1:0] start_h;
      bit               hires;
      bit               fill;
      logic [OP_W-1:0]  op;
      logic [COL_W-1:0] col;
      logic [RND_W-1:0] rnd;
      logic [ROW_W-1:0] row;
      bit               typed;
      logic             take_old;
      logic [ROW_W-1:0] old_row;
      logic             finished;
      logic             in_progress;
   } dir_row_type;

   localparam int DIR_ROWS = 23;

   dir_row_type dir_tab [DIR_ROWS] = '{
      // unused code right after reset: wipe flag still clear
      '{0, 0,   0, 0, OP_UNUSED, 10'd0,    8'd0,   9'd0,   1, 0, 9'd0,   0, 0},
      // seeds past the last column are dropped and do not start the wipe
      '{0, 0,   0, 0, OP_SEED,   10'd700,  8'hFF,  9'h1FF, 1, 0, 9'd0,   0, 0},
      '{0, 0,   0, 0, OP_SEED,   10'd320,  8'd0,   9'd0,   1, 0, 9'd0,   0, 0},
      // start of 400: column 0 sits below the screen
      '{1, 400, 0, 0, OP_SEED,   10'd0,    8'd0,   9'd0,   1, 0, 9'd0,   0, 1},
      '{0, 0,   0, 0, OP_QUERY,  10'd0,    8'd0,   9'd399, 1, 0, 9'd0,   0, 1},
      '{0, 0,   0, 0, OP_QUERY,  10'd0,    8'd0,   9'd199, 1, 0, 9'd0,   0, 1},
      '{0, 0,   0, 0, OP_SEED,   10'd0,    8'hFF,  9'd0,   1, 0, 9'd0,   0, 1},
      // zero start in high res: column 0 lands at -15
      '{1, 0,   1, 0, OP_SEED,   10'd0,    8'h0F,  9'd0,   1, 0, 9'd0,   0, 1},
      '{0, 0,   0, 0, OP_QUERY,  10'd1,    8'd0,   9'd0,   1, 1, 9'd0,   0, 1},
      '{0, 0,   0, 0, OP_QUERY,  10'd0,    8'd0,   9'd399, 1, 1, 9'd399, 0, 1},
      '{0, 0,   0, 0, OP_QUERY,  10'd1023, 8'd0,   9'd511, 1, 0, 9'd0,   0, 1},
      // -16 clamps to -15, then a rise, then the last column
      '{0, 0,   0, 0, OP_SEED,   10'd1,    8'd0,   9'd0,   0, 0, 9'd0,   0, 0},
      '{0, 0,   0, 0, OP_SEED,   10'd2,    8'd2,   9'd0,   0, 0, 9'd0,   0, 0},
      '{0, 0,   0, 0, OP_SEED,   10'd319,  8'd1,   9'd0,   0, 0, 9'd0,   0, 0},
      '{1, 0,   0, 0, OP_QUERY,  10'd319,  8'd0,   9'd0,   0, 0, 9'd0,   0, 0},
      // every column seeded before the first tick
      '{0, 0,   0, 1, OP_TICK,   10'd0,    8'd0,   9'd0,   0, 0, 9'd0,   0, 0},
      '{0, 0,   0, 0, OP_TICK,   10'd1023, 8'hFF,  9'h1FF, 0, 0, 9'd0,   0, 0},
      '{1, 0,   1, 0, OP_QUERY,  10'd639,  8'hA5,  9'd256, 0, 0, 9'd0,   0, 0},
      '{0, 0,   0, 0, OP_QUERY,  10'd512,  8'd0,   9'd17,  0, 0, 9'd0,   0, 0},
      '{0, 0,   0, 0, OP_UNUSED, 10'd1023, 8'hFF,  9'h1FF, 0, 0, 9'd0,   0, 0},
      '{1, 200, 1, 0, OP_SEED,   10'd0,    8'd7,   9'd0,   0, 0, 9'd0,   0, 0},
      '{0, 0,   0, 0, OP_TICK,   10'd0,    8'd0,   9'd0,   0, 0, 9'd0,   0, 0},
      '{0, 0,   0, 0, OP_QUERY,  10'd0,    8'd0,   9'd250, 0, 0, 9'd0,   0, 0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cmw_req_if req_bus ();
   cmw_rsp_if rsp_bus ();

   column_melt_wipe_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // own copy of the melt state and registers
   cmw_ofs_type        melt_ofs [COLUMNS];
   cmw_ofs_type        last_ofs;
   bit                 wipe_on;
   logic [START_W-1:0] cfg_start;
   bit                 cfg_hires;

   // answers still owed by the block, oldest first
   melt_answer_type melt_answers [$];
   melt_answer_type no_answer = '{1'b0, '0, 1'b0, 1'b0};

   // control flags; idle_on and hold_req are shared between the two sides
   bit idle_on;
   bit hold_req;
   bit last_tick_done;

   // run statistics
   int items_sent;
   int tick_count;
   int finish_count;
   int shown_count;
   int csr_writes;
   int mismatch_count;
   int cycle_count;

   // next state and answer of the melt for one accepted item
   function automatic melt_answer_type advance_melt(input melt_item_type it);
      melt_answer_type ans;
      int h, v, w, dy, d, y, lc, x;
      bit all_still;
      ans = '{1'b0, '0, 1'b0, 1'b0};
      h = SCREEN_ROWS << cfg_hires;
      y = int'(it.row);
      lc = int'(it.col >> cfg_hires);
      if (it.op == OP_SEED && it.col < COLUMNS) begin
         if (it.col == 0) begin
            v = int'(cfg_start) - int'(it.rnd % 16);
         end else begin
            // drift from the previous column, never above 0, never below -15
            v = int'(last_ofs) + int'(it.rnd % 3) - 1;
            if (v > 0)
               v = 0;
            else if (v == -16)
               v = -15;
         end
         melt_ofs[ADDR_W'(it.col)] = OFS_W'(v);
         last_ofs = OFS_W'(v);
         wipe_on = 1'b1;
      end else if (it.op == OP_TICK) begin
         all_still = 1'b1;
         for (x = 0; x < COLUMNS; x++) begin
            w = melt_ofs[x];
            if (w < 0) begin
               melt_ofs[x] = OFS_W'(w + 1);
               all_still = 1'b0;
            end else if (w < h) begin
               // accelerate while shallow, then fall at a fixed speed
               dy = (w < 16) ? w + 1 : 8;
               if (w + dy >= h)
                  dy = h - w;
               melt_ofs[x] = OFS_W'(w + dy);
               all_still = 1'b0;
            end
         end
         if (all_still)
            wipe_on = 1'b0;
         ans.finished = all_still;
      end else if (it.op == OP_QUERY && lc < COLUMNS) begin
         d = melt_ofs[lc];
         if (d < 0)
            d = 0;
         if (y >= d && y < h) begin
            ans.take_old = 1'b1;
            ans.old_row = ROW_W'(y - d);
         end
      end
      ans.in_progress = wipe_on;
      return ans;
   endfunction

   // item with every field random and the given operation
   function automatic melt_item_type random_item(input logic [OP_W-1:0] op);
      melt_item_type it;
      it.op = op;
      it.col = COL_W'($urandom_range(0, 1023));
      it.rnd = RND_W'($urandom_range(0, 255));
      it.row = ROW_W'($urandom_range(0, 511));
      return it;
   endfunction

   // query mostly on the visible screen, now and then anywhere in the field range
   function automatic melt_item_type make_query();
      melt_item_type it;
      it = random_item(OP_QUERY);
      if ($urandom_range(0, 9) != 0) begin
         it.col = COL_W'($urandom_range(0, (COLUMNS << cfg_hires) - 1));
         it.row = ROW_W'($urandom_range(0, (SCREEN_ROWS << cfg_hires) - 1));
      end
      return it;
   endfunction

   // items the block drops, and queries anywhere in the field range
   function automatic melt_item_type make_noise();
      melt_item_type it;
      case ($urandom_range(0, 2))
         0: it = random_item(OP_UNUSED);
         1: begin
            it = random_item(OP_SEED);
            it.col = COL_W'($urandom_range(COLUMNS, 1023));
         end
         default: it = random_item(OP_QUERY);
      endcase
      return it;
   endfunction

   // offer one item, entered and left at a falling edge with valid still up
   task automatic send_item(input melt_item_type it, input bit typed,
                            input melt_answer_type fixed);
      int gap;
      melt_answer_type ans;
      gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.operation = it.op;
      req_bus.column = it.col;
      req_bus.random_byte = it.rnd;
      req_bus.row = it.row;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      // accepted: state moves now, answer is owed
      ans = advance_melt(it);
      if (it.op == OP_TICK) begin
         last_tick_done = ans.finished;
         tick_count++;
         if (ans.finished)
            finish_count++;
      end
      if (ans.take_old)
         shown_count++;
      if (!(it.op == OP_UNUSED || (it.op == OP_SEED && it.col >= COLUMNS)))
         items_sent++;
      melt_answers.push_back(typed ? fixed : ans);
      @(negedge clock);
   endtask

   // seed a run of columns in order with random bytes, with noise items now and then if noisy
   task automatic seed_run(input int first_col, input int last_col, input bit noisy);
      melt_item_type it;
      int c;
      for (c = first_col; c <= last_col; c++) begin
         if (noisy && $urandom_range(0, 15) == 0)
            send_item(make_noise(), 1'b0, no_answer);
         it = random_item(OP_SEED);
         it.col = COL_W'(c);
         send_item(it, 1'b0, no_answer);
      end
   endtask

   // drop valid and wait until every owed answer is back
   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (melt_answers.size() != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input cmw_csr_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      csr_writes++;
   endtask

   // registers only change with the block idle
   task automatic apply_config(input logic [START_W-1:0] start_h, input bit hires);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_reg(CSR_START_HEIGHT, CSR_DATA_W'(start_h));
      write_reg(CSR_HIGH_RES, CSR_DATA_W'(hires));
      cfg_start = start_h;
      cfg_hires = hires;
   endtask

   task automatic compare_field(input string name, input logic [ROW_W-1:0] want_v,
                                input logic [ROW_W-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request, field-by-field check
   initial begin : result_side
      int stall;
      melt_answer_type want;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_req) begin
            // long hold-off so the output register fills and the input stalls
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end
         stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (stall != 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         @(posedge clock);
         while (rsp_bus.valid !== 1'b1)
            @(posedge clock);
         if (melt_answers.size() == 0) begin
            $display("%0t: unexpected result: take_old=%0b old_row=%0d",
                     $time, rsp_bus.take_old, rsp_bus.old_row);
            $display("%0t: unexpected result: finished=%0b in_progress=%0b",
                     $time, rsp_bus.finished, rsp_bus.in_progress);
            mismatch_count++;
         end else begin
            want = melt_answers.pop_front();
            compare_field("take_old", ROW_W'(want.take_old), ROW_W'(rsp_bus.take_old));
            compare_field("old_row", want.old_row, rsp_bus.old_row);
            compare_field("finished", ROW_W'(want.finished), ROW_W'(rsp_bus.finished));
            compare_field("in_progress", ROW_W'(want.in_progress),
                          ROW_W'(rsp_bus.in_progress));
         end
         @(negedge clock);
      end
   end

   // stimulus: directed table, then wipe episodes with random content
   initial begin : item_side
      int r;
      int episode;
      int first_col;
      int last_col;
      int n;
      int ticks;
      logic [START_W-1:0] new_start;
      melt_item_type it;
      melt_answer_type fixed;

      // every input known from time zero
      req_bus.valid = 1'b0;
      req_bus.operation = OP_SEED;
      req_bus.column = '0;
      req_bus.random_byte = '0;
      req_bus.row = '0;
      csr_we = 1'b0;
      csr_index = CSR_START_HEIGHT;
      csr_wdata = '0;
      idle_on = 1'b1;
      hold_req = 1'b0;
      last_tick_done = 1'b0;
      last_ofs = '0;
      wipe_on = 1'b0;
      cfg_start = '0;
      cfg_hires = 1'b0;
      foreach (melt_ofs[i])
         melt_ofs[i] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part
      for (r = 0; r < DIR_ROWS; r++) begin
         if (dir_tab[r].set_cfg)
            apply_config(dir_tab[r].start_h, dir_tab[r].hires);
         if (dir_tab[r].fill)
            seed_run(0, COLUMNS - 1, 1'b0);
         it = '{dir_tab[r].op, dir_tab[r].col, dir_tab[r].rnd, dir_tab[r].row};
         fixed = '{dir_tab[r].take_old, dir_tab[r].old_row, dir_tab[r].finished,
                   dir_tab[r].in_progress};
         send_item(it, dir_tab[r].typed, fixed);
      end

      // random part: each episode reseeds some columns and ticks until the wipe ends or the tick cap is reached
      episode = 0;
      while (items_sent < ITEM_TARGET) begin
         episode++;
         if (episode == 1 || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 5))
               0: new_start = '0;
               1: new_start = 9'd400;
               2: new_start = START_W'(START_MAX);
               default: new_start = START_W'($urandom_range(0, 400));
            endcase
            apply_config(new_start, 1'($urandom_range(0, 1)));
         end
         idle_on = ($urandom_range(0, 4) != 0);
         if (episode == 2) begin
            // sender keeps offering with no gaps while the receiver holds off
            idle_on = 1'b0;
            hold_req = 1'b1;
         end

         // reseed: usually from column 0, sometimes a whole pass, sometimes mid-screen
         first_col = ($urandom_range(0, 4) == 0) ? $urandom_range(1, COLUMNS - 1) : 0;
         n = ($urandom_range(0, 5) == 0) ? COLUMNS : $urandom_range(1, 40);
         last_col = first_col + n - 1;
         if (last_col > COLUMNS - 1)
            last_col = COLUMNS - 1;
         seed_run(first_col, last_col, 1'b1);

         // tick until every column has landed or the tick cap is reached, with queries in between
         ticks = 0;
         do begin
            n = $urandom_range(0, 3);
            repeat (n) send_item(make_query(), 1'b0, no_answer);
            if ($urandom_range(0, 7) == 0)
               send_item(make_noise(), 1'b0, no_answer);
            if ($urandom_range(0, 19) == 0)
               drain_results();
            if ($urandom_range(0, 29) == 0)
               idle_on = ~idle_on;
            send_item(random_item(OP_TICK), 1'b0, no_answer);
            ticks++;
         end while (!last_tick_done && ticks < TICK_CAP);

         // tick on a finished wipe
         if ($urandom_range(0, 2) == 0)
            send_item(random_item(OP_TICK), 1'b0, no_answer);
      end

      // wind down
      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d items over %0d wipe episodes: %0d ticks, %0d wipes finished",
               items_sent, episode, tick_count, finish_count);
      $display("%0d queries showed the old image, %0d register writes, %0d mismatches",
               shown_count, csr_writes, mismatch_count);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
